// ===== hw/rtl/softmax_vector_engine_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SOFTMAX_VECTOR_ENGINE_ASSERT_SVH
`define SOFTMAX_VECTOR_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("softmax_vector_engine: same-cycle check failed");

// Next-cycle implication.
`define SVE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("softmax_vector_engine: next-cycle check failed");

`endif

// ===== hw/rtl/sve_pkg.sv =====
package sve_pkg;

	// Default and upper bound of the vector length
	localparam int VECTOR_MAX_DEF = 64;

	// Fixed-point constants
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam int          SERIES_TERMS = 10;
	localparam int          LOG_FRAC_BITS = 20;
	localparam int          DIV_BITS = 17;

	// Datapath widths
	localparam int LOGIT_W  = 16;
	localparam int EXP_W    = 17;
	localparam int SUM_W    = 23;
	localparam int RESULT_W = 17;
	localparam int MUL_W    = 36;

	// Register map (word index)
	localparam logic REG_LOG_MODE = 1'b0;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_EXP_RD,
		ST_EXP_MUL_T,
		ST_EXP_MUL_F,
		ST_EXP_TERM,
		ST_EXP_DIV,
		ST_EXP_DONE,
		ST_LN_INIT,
		ST_LN_SQ,
		ST_LN_MUL,
		ST_OUT_RD,
		ST_OUT_CALC,
		ST_OUT_DIV,
		ST_OUT_SEND
	} sve_state_t;

	// ceil(2^36 / k): floor(x / k) = (x * recip) >> 36 for any 32-bit x
	function automatic logic [MUL_W-1:0] recip_k(input logic [3:0] k);
		logic [MUL_W-1:0] r;
		unique case (k)
			4'd2:    r = 36'd34359738368;
			4'd3:    r = 36'd22906492246;
			4'd4:    r = 36'd17179869184;
			4'd5:    r = 36'd13743895348;
			4'd6:    r = 36'd11453246123;
			4'd7:    r = 36'd9817068106;
			4'd8:    r = 36'd8589934592;
			4'd9:    r = 36'd7635497416;
			4'd10:   r = 36'd6871947674;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/sve_ram.sv =====
module sve_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/softmax_vector_engine.sv =====
// Channel   Direction  Transfer                       Payload
// s_*       in         s_tvalid & s_tready            tdata = logit, tlast = last_in
// m_*       out        m_tvalid & m_tready            tdata = result_value, tlast = last_out
// APB       in         psel & penable & pwrite        log_mode at byte address 0
//
// Loading writes each accepted element to the logit buffer. The item with tlast (or the one that fills the
// buffer) starts the passes: exp (shared 36x36 multiplier, two uses per series term), then ln, then
// output, with a bit-serial divider per element in softmax mode. s_tready is high only while loading.
// Reset clears the sequencer, vector count, running max, sum and log_mode.
// A stalled m_tready holds the output register and the sequencer waits in the send step.
module softmax_vector_engine
	import sve_pkg::*;
#(
	parameter int VECTOR_MAX = VECTOR_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] logit
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [16:0] result_value, [23:17] zero
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(VECTOR_MAX + 1);
	localparam int AW = $clog2(VECTOR_MAX);

	sve_state_t state_q, state_d;

	logic [CW-1:0]             cnt_q, idx_q;
	logic signed [LOGIT_W-1:0] max_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      log_mode_q;
	logic [4:0]                n_q;
	logic                      ezero_q;
	logic [31:0]               f_q, y_q, quot_q;
	logic [32:0]               s_q, term_q;
	logic [3:0]                k_q;
	logic [30:0]               m_q;
	logic [2:0]                kk_q;
	logic [LOG_FRAC_BITS-1:0]  frac_q;
	logic [4:0]                it_q;
	logic [13:0]               lsum_q;
	logic [SUM_W:0]            rem_q;
	logic [DIV_BITS-1:0]       num_q, qbits_q;
	logic [RESULT_W-1:0]       res_q, out_data_q;
	logic                      out_valid_q, out_last_q;

	// Control outputs of the sequencer
	logic                   in_accept, logit_we, exp_we, out_load;
	logic [MUL_W-1:0]       mul_a, mul_b;
	logic [2*MUL_W-1:0]     prod;
	logic [LOGIT_W-1:0]     logit_rdata;
	logic [EXP_W-1:0]       exp_rdata, exp_val;
	logic                   end_vec, last_idx, cfg_write;
	logic [LOGIT_W-1:0]     t_val;
	logic [31:0]            term_new;
	logic [33:0]            e_round;
	logic [2:0]             kk_new;
	logic [44:0]            m_shift;
	logic [31:0]            sq_val;
	logic [2*MUL_W-1:0]     ln_round;
	logic signed [18:0]     log_v;
	logic [33:0]            num_full;
	logic [SUM_W:0]         rem_sh;
	logic                   rem_ge;
	logic [DIV_BITS-1:0]    qbits_new;

	// Buffers
	sve_ram #(.WIDTH(LOGIT_W), .DEPTH(VECTOR_MAX)) u_logit_ram (
		.clk   (clk),
		.we    (logit_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (s_tdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (logit_rdata)
	);

	sve_ram #(.WIDTH(EXP_W), .DEPTH(VECTOR_MAX)) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (exp_val),
		.raddr (idx_q[AW-1:0]),
		.rdata (exp_rdata)
	);

	// Shared multiplier
	assign prod = mul_a * mul_b;

	assign in_accept = s_tvalid & s_tready;
	assign end_vec   = s_tlast | (cnt_q + CW'(1) == CW'(VECTOR_MAX));
	assign last_idx  = (idx_q + CW'(1) == cnt_q);
	assign cfg_write = psel & penable & pwrite & pready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:      if (in_accept && end_vec) state_d = ST_EXP_RD;
			ST_EXP_RD:    state_d = ST_EXP_MUL_T;
			ST_EXP_MUL_T: state_d = ST_EXP_MUL_F;
			ST_EXP_MUL_F: state_d = ST_EXP_TERM;
			ST_EXP_TERM:  state_d = ST_EXP_DIV;
			ST_EXP_DIV:   state_d = (k_q == 4'(SERIES_TERMS)) ? ST_EXP_DONE : ST_EXP_TERM;
			ST_EXP_DONE:  state_d = last_idx ? ST_LN_INIT : ST_EXP_RD;
			ST_LN_INIT:   state_d = ST_LN_SQ;
			ST_LN_SQ:     if (it_q == 5'(LOG_FRAC_BITS - 1)) state_d = ST_LN_MUL;
			ST_LN_MUL:    state_d = ST_OUT_RD;
			ST_OUT_RD:    state_d = ST_OUT_CALC;
			ST_OUT_CALC:  state_d = log_mode_q ? ST_OUT_SEND : ST_OUT_DIV;
			ST_OUT_DIV:   if (it_q == 5'(DIV_BITS - 1)) state_d = ST_OUT_SEND;
			ST_OUT_SEND: begin
				if (out_load) state_d = last_idx ? ST_LOAD : ST_OUT_RD;
			end
			default:      state_d = ST_LOAD;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		logit_we = 1'b0;
		exp_we   = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				logit_we = in_accept;
			end
			ST_EXP_MUL_T: begin
				mul_a = MUL_W'(t_val);
				mul_b = MUL_W'(LOG2E_Q30);
			end
			ST_EXP_MUL_F: begin
				mul_a = MUL_W'(f_q);
				mul_b = MUL_W'(LN2_Q32);
			end
			ST_EXP_TERM: begin
				mul_a = MUL_W'(term_q);
				mul_b = MUL_W'(y_q);
			end
			ST_EXP_DIV: begin
				mul_a = MUL_W'(quot_q);
				mul_b = recip_k(k_q);
			end
			ST_EXP_DONE: exp_we = 1'b1;
			ST_LN_SQ: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q);
			end
			ST_LN_MUL: begin
				mul_a = MUL_W'({kk_q, frac_q});
				mul_b = MUL_W'(LN2_Q32);
			end
			ST_OUT_SEND: out_load = ~out_valid_q | m_tready;
			default: begin
			end
		endcase
	end

	// Datapath helpers
	always_comb begin
		t_val    = LOGIT_W'(max_q - $signed(logit_rdata));
		term_new = (k_q == 4'd1) ? quot_q : prod[67:36];
		e_round  = {1'b0, s_q} + (34'd1 << (5'd15 + n_q));
		exp_val  = ezero_q ? '0 : EXP_W'(e_round >> (6'd16 + 6'(n_q)));

		kk_new = 3'd0;
		for (int b = 17; b < SUM_W; b++) begin
			if (sum_q[b]) kk_new = 3'(b - 16);
		end
		m_shift = 45'(sum_q) << (5'd14 - 5'(kk_new));
		sq_val  = prod[61:30];
		ln_round = prod + (72'd1 << 41);

		log_v = 19'($signed(logit_rdata)) - 19'(max_q) - 19'(lsum_q);
		num_full = {1'b0, exp_rdata, 16'd0} + 34'(sum_q >> 1);

		rem_sh    = {rem_q[SUM_W-1:0], num_q[DIV_BITS-1]};
		rem_ge    = rem_sh >= (SUM_W+1)'(sum_q);
		qbits_new = {qbits_q[DIV_BITS-2:0], rem_ge};
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			idx_q       <= '0;
			max_q       <= 16'sh8000;
			sum_q       <= '0;
			log_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && paddr[2] == REG_LOG_MODE) log_mode_q <= pwdata[0];

			if (in_accept) begin
				cnt_q <= cnt_q + CW'(1);
				if ($signed(s_tdata) > max_q) max_q <= $signed(s_tdata);
				idx_q <= '0;
				sum_q <= '0;
			end

			if (state_q == ST_EXP_DONE) begin
				sum_q <= sum_q + SUM_W'(exp_val);
				idx_q <= last_idx ? '0 : idx_q + CW'(1);
			end

			if (out_load) begin
				idx_q <= idx_q + CW'(1);
				if (last_idx) begin
					cnt_q <= '0;
					max_q <= 16'sh8000;
					sum_q <= '0;
				end
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Arithmetic registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_EXP_MUL_T: begin
				f_q     <= prod[39:8];
				n_q     <= prod[44:40];
				ezero_q <= prod[46:40] > 7'd16;
			end
			ST_EXP_MUL_F: begin
				y_q    <= prod[63:32];
				s_q    <= 33'h1_0000_0000;
				term_q <= 33'h1_0000_0000;
				k_q    <= 4'd1;
			end
			ST_EXP_TERM: quot_q <= prod[63:32];
			ST_EXP_DIV: begin
				term_q <= 33'(term_new);
				s_q    <= k_q[0] ? s_q - 33'(term_new) : s_q + 33'(term_new);
				k_q    <= k_q + 4'd1;
			end
			ST_LN_INIT: begin
				m_q    <= m_shift[30:0];
				kk_q   <= kk_new;
				frac_q <= '0;
				it_q   <= '0;
			end
			ST_LN_SQ: begin
				it_q <= it_q + 5'd1;
				if (sq_val[31]) begin
					m_q    <= sq_val[31:1];
					frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b1};
				end else begin
					m_q    <= sq_val[30:0];
					frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b0};
				end
			end
			ST_LN_MUL: lsum_q <= ln_round[55:42];
			ST_OUT_CALC: begin
				res_q   <= (log_v < -19'sd65536) ? 17'h1_0000 : log_v[16:0];
				rem_q   <= (SUM_W+1)'(num_full[33:17]);
				num_q   <= num_full[16:0];
				qbits_q <= '0;
				it_q    <= '0;
			end
			ST_OUT_DIV: begin
				rem_q   <= rem_ge ? rem_sh - (SUM_W+1)'(sum_q) : rem_sh;
				num_q   <= {num_q[DIV_BITS-2:0], 1'b0};
				qbits_q <= qbits_new;
				it_q    <= it_q + 5'd1;
				res_q   <= qbits_new[16] ? 17'h0_FFFF : qbits_new;
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
			out_last_q <= last_idx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_data_q};
	assign m_tlast  = out_last_q;
	assign prdata   = {31'd0, log_mode_q};
	assign pready   = 1'b1;

endmodule

// ===== hw/rtl/sve_checker.sv =====
`include "softmax_vector_engine_assert.svh"

module sve_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result holds
	`SVE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// No new vector is taken while a non-final result is pending
	`SVE_ASSERT_NOW(a_no_load_mid_vector, m_tvalid && !m_tlast, !s_tready)

	// Padding bits above the result stay zero
	`SVE_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[23:17] == 7'd0)

endmodule

bind softmax_vector_engine sve_checker u_sve_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
